[hw/rtl/fgls_pkg.sv]
// Shared types, constants and the level lookup for the fuel gauge level slew block.
package fgls_pkg;

    localparam int unsigned PCT_W      = 8;
    localparam int unsigned LEVEL_W    = 3;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_BOUNDS = 5;

    localparam logic [PCT_W-1:0]   INVALID_PERCENT = 8'hFF;
    localparam logic [TICK_W-1:0]  TICK_MAX        = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY     = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 3'd5;

    // Input item kinds.
    localparam logic ACTION_TICK   = 1'b0;
    localparam logic ACTION_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_UPPER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_UPPER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_UPPER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_UPPER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL4_UPPER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_BIG_GAP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_SMALL_GAP = 3'd6;

    localparam logic [PCT_W-1:0]  RST_LEVEL0_UPPER   = 8'd10;
    localparam logic [PCT_W-1:0]  RST_LEVEL1_UPPER   = 8'd25;
    localparam logic [PCT_W-1:0]  RST_LEVEL2_UPPER   = 8'd45;
    localparam logic [PCT_W-1:0]  RST_LEVEL3_UPPER   = 8'd65;
    localparam logic [PCT_W-1:0]  RST_LEVEL4_UPPER   = 8'd85;
    localparam logic [TICK_W-1:0] RST_WAIT_BIG_GAP   = 16'd300;
    localparam logic [TICK_W-1:0] RST_WAIT_SMALL_GAP = 16'd600;

    typedef logic [NUM_BOUNDS-1:0][PCT_W-1:0] t_bounds;

    // The lowest level whose upper bound the percentage does not exceed wins.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [PCT_W-1:0] pct,
                                                     input t_bounds bounds);
        logic [LEVEL_W-1:0] lv;
        lv = LEVEL_FULL;
        for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
            if (pct <= bounds[i]) begin
                lv = LEVEL_W'(i);
            end
        end
        if (pct == INVALID_PERCENT) begin
            lv = LEVEL_EMPTY;
        end
        return lv;
    endfunction

endpackage

[hw/rtl/fuel_gauge_level_slew.sv]
// Fuel gauge level slew filter: input register, update logic and result register.

// Each transfer on the input channel is a timer tick or a gauge update and produces
// exactly one result transfer. An item waits in the input register until the result
// register is empty or is being emptied, then moves into the result register, from
// which its result is offered to the output side. A new item can
// be taken every cycle while the output side keeps up. The level, warning and tick
// counter state is updated in the cycle an item moves into the result register. The
// input stalls only while both the input and the result register hold an item and
// the output side stalls. Configuration writes are always ready and take effect at
// once; write them only while no item is in flight.
module fuel_gauge_level_slew
    import fgls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [PCT_W-1:0]      i_fuel_percent,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_display_write,
    output logic [LEVEL_W-1:0]    o_shown_level,
    output logic                  o_low_fuel_warning,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    t_bounds           r_bounds;
    logic [TICK_W-1:0] r_wait_big;
    logic [TICK_W-1:0] r_wait_small;

    // Input register.
    logic              r_in_vld;
    logic              r_action;
    logic [PCT_W-1:0]  r_pct;

    // Filter state.
    logic               r_started,  n_started;
    logic [LEVEL_W-1:0] r_level,    n_level;
    logic [TICK_W-1:0]  r_tick,     n_tick;
    logic               r_warning,  n_warning;
    logic               n_write;

    // Result register.
    logic               r_out_vld;
    logic               r_out_write;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_warning;

    logic               advance;
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W-1:0] gap;
    logic               hold;

    assign o_cfg_ready = 1'b1;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds[0]  <= RST_LEVEL0_UPPER;
            r_bounds[1]  <= RST_LEVEL1_UPPER;
            r_bounds[2]  <= RST_LEVEL2_UPPER;
            r_bounds[3]  <= RST_LEVEL3_UPPER;
            r_bounds[4]  <= RST_LEVEL4_UPPER;
            r_wait_big   <= RST_WAIT_BIG_GAP;
            r_wait_small <= RST_WAIT_SMALL_GAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LEVEL0_UPPER:   r_bounds[0]  <= i_cfg_data[PCT_W-1:0];
                REG_LEVEL1_UPPER:   r_bounds[1]  <= i_cfg_data[PCT_W-1:0];
                REG_LEVEL2_UPPER:   r_bounds[2]  <= i_cfg_data[PCT_W-1:0];
                REG_LEVEL3_UPPER:   r_bounds[3]  <= i_cfg_data[PCT_W-1:0];
                REG_LEVEL4_UPPER:   r_bounds[4]  <= i_cfg_data[PCT_W-1:0];
                REG_WAIT_BIG_GAP:   r_wait_big   <= i_cfg_data[TICK_W-1:0];
                REG_WAIT_SMALL_GAP: r_wait_small <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= i_action;
            r_pct    <= i_fuel_percent;
        end
    end

    assign target = level_of(r_pct, r_bounds);
    assign gap    = (target > r_level) ? target - r_level : r_level - target;
    assign hold   = (gap >= LEVEL_W'(2) && r_tick < r_wait_big) ||
                    (gap == LEVEL_W'(1) && r_tick < r_wait_small);

    always_comb begin
        n_started = r_started;
        n_level   = r_level;
        n_tick    = r_tick;
        n_warning = r_warning;
        n_write   = 1'b0;
        if (r_action == ACTION_TICK) begin
            if (r_tick != TICK_MAX) begin
                n_tick = r_tick + TICK_W'(1);
            end
        end else if (!r_started) begin
            // The first update jumps straight to the target level.
            n_started = 1'b1;
            n_level   = target;
            n_warning = (target == LEVEL_EMPTY);
            n_write   = 1'b1;
            n_tick    = '0;
        end else if (!hold) begin
            n_tick = '0;
            if (r_level < target) begin
                n_level = r_level + LEVEL_W'(1);
            end else if (r_level > target) begin
                n_level = r_level - LEVEL_W'(1);
            end
            if (n_level == LEVEL_EMPTY) begin
                // An empty display is redrawn only when the warning first comes on.
                n_write   = !r_warning;
                n_warning = 1'b1;
            end else begin
                n_warning = 1'b0;
                n_write   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_level   <= LEVEL_EMPTY;
            r_tick    <= '0;
            r_warning <= 1'b0;
        end else if (advance) begin
            r_started <= n_started;
            r_level   <= n_level;
            r_tick    <= n_tick;
            r_warning <= n_warning;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_write   <= n_write;
            r_out_level   <= n_level;
            r_out_warning <= n_warning;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_display_write    = r_out_write;
    assign o_shown_level      = r_out_level;
    assign o_low_fuel_warning = r_out_warning;

    // The warning tracks an empty display once the gauge has started.
    a_warning_matches_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warning == (r_started && r_level == LEVEL_EMPTY))
        else $error("warning flag disagrees with displayed level");

    // After the first update the displayed level moves by at most one step.
    a_level_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_started) && r_started) |->
            (r_level == $past(r_level) ||
             r_level == LEVEL_W'($past(r_level) + LEVEL_W'(1)) ||
             r_level == LEVEL_W'($past(r_level) - LEVEL_W'(1))))
        else $error("displayed level jumped by more than one step");

    // The displayed level never leaves its range.
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_FULL)
        else $error("displayed level out of range");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the fuel gauge level slew block.
`timescale 1ns / 1ps

module testbench;
    import fgls_pkg::*;

    typedef struct packed {
        logic               display_write;
        logic [LEVEL_W-1:0] shown_level;
        logic               low_fuel_warning;
    } t_gauge_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  act;
        logic [PCT_W-1:0]      pct;
        logic                  pinned;
        t_gauge_result         res;
    } t_stim_row;

    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 48;
    localparam int DRAIN_CYCLES = 4;
    localparam int SEGMENT_ITEMS = 56;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_action = ACTION_TICK;
    logic [PCT_W-1:0]      i_fuel_percent = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_display_write;
    logic [LEVEL_W-1:0]    o_shown_level;
    logic                  o_low_fuel_warning;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_LEVEL0_UPPER;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Fixed expectation travelling alongside the offered item.
    logic          row_pinned = 1'b0;
    t_gauge_result row_result = '0;

    // Shadow copy of the registers and the gauge state.
    logic [PCT_W-1:0]  upper_bound [NUM_BOUNDS] = '{RST_LEVEL0_UPPER, RST_LEVEL1_UPPER,
        RST_LEVEL2_UPPER, RST_LEVEL3_UPPER, RST_LEVEL4_UPPER};
    logic [TICK_W-1:0] wait_far = RST_WAIT_BIG_GAP;
    logic [TICK_W-1:0] wait_near = RST_WAIT_SMALL_GAP;
    logic               seen_update = 1'b0;
    logic [LEVEL_W-1:0] shown_lvl = LEVEL_EMPTY;
    logic [TICK_W-1:0]  tick_cnt = '0;
    logic               warn_lit = 1'b0;

    t_gauge_result level_q [$];
    int            mismatches = 0;
    int            send_idle_pct = 23;
    int            recv_idle_pct = 69;
    int            hold_left = 0;
    logic          hold_req = 1'b0;

    fuel_gauge_level_slew u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_fuel_percent     (i_fuel_percent),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_display_write    (o_display_write),
        .o_shown_level      (o_shown_level),
        .o_low_fuel_warning (o_low_fuel_warning),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // Advances the shadow gauge by one item and returns the result it should produce.
    function automatic t_gauge_result step_gauge(input logic act, input logic [PCT_W-1:0] pct);
        t_gauge_result      r;
        logic [LEVEL_W-1:0] goal;
        logic [LEVEL_W-1:0] gap;
        logic               found;
        logic               held;
        r = '0;
        if (act == ACTION_TICK) begin
            if (tick_cnt != TICK_MAX) begin
                tick_cnt = tick_cnt + TICK_W'(1);
            end
        end else begin
            goal = LEVEL_FULL;
            found = 1'b0;
            for (int i = 0; i < NUM_BOUNDS; i++) begin
                if (!found && pct <= upper_bound[i]) begin
                    goal = LEVEL_W'(i);
                    found = 1'b1;
                end
            end
            if (pct == INVALID_PERCENT) begin
                goal = LEVEL_EMPTY;
            end
            if (!seen_update) begin
                seen_update = 1'b1;
                shown_lvl = goal;
                warn_lit = (goal == LEVEL_EMPTY);
                r.display_write = 1'b1;
            end
            gap = (goal > shown_lvl) ? goal - shown_lvl : shown_lvl - goal;
            held = (gap >= LEVEL_W'(2) && tick_cnt < wait_far) ||
                   (gap == LEVEL_W'(1) && tick_cnt < wait_near);
            if (!held) begin
                tick_cnt = '0;
                if (shown_lvl < goal) begin
                    shown_lvl = shown_lvl + LEVEL_W'(1);
                end else if (shown_lvl > goal) begin
                    shown_lvl = shown_lvl - LEVEL_W'(1);
                end
                if (shown_lvl == LEVEL_EMPTY) begin
                    // Reaching empty rewrites the display only when the warning turns on.
                    if (!warn_lit) begin
                        r.display_write = 1'b1;
                        warn_lit = 1'b1;
                    end
                end else begin
                    warn_lit = 1'b0;
                    r.display_write = 1'b1;
                end
            end
        end
        r.shown_level = shown_lvl;
        r.low_fuel_warning = warn_lit;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic act, input logic [PCT_W-1:0] pct);
        t_stim_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.act = act;
        row.pct = pct;
        return row;
    endfunction

    function automatic t_stim_row pinned_row(input logic act, input logic [PCT_W-1:0] pct,
                                             input logic wr, input logic [LEVEL_W-1:0] lvl,
                                             input logic warn);
        t_stim_row row;
        row = item_row(act, pct);
        row.pinned = 1'b1;
        row.res = '{wr, lvl, warn};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // Offers one item, with random idle cycles ahead of it, and returns once it is taken.
    task automatic push_item(input logic act, input logic [PCT_W-1:0] pct,
                             input logic pin, input t_gauge_result res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_fuel_percent <= pct;
        row_pinned <= pin;
        row_result <= res;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Waits until every expected result has come back and the pipeline is empty.
    // The first edge lets the monitor record the last transfer before the queue is read.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (level_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The upper byte of a bound write carries junk that the block must drop.
    task automatic load_gauge_settings(input t_bounds bnd, input logic [TICK_W-1:0] far_w,
                                       input logic [TICK_W-1:0] near_w);
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            write_reg(REG_LEVEL0_UPPER + CFG_IDX_W'(i), {PCT_W'($urandom), bnd[i]});
        end
        write_reg(REG_WAIT_BIG_GAP, far_w);
        write_reg(REG_WAIT_SMALL_GAP, near_w);
    endtask

    function automatic logic [TICK_W-1:0] pick_wait();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 9) begin
            return TICK_W'($urandom_range(10, 40));
        end
        return TICK_W'($urandom_range(1, 6));
    endfunction

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_gauge_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LEVEL0_UPPER, REG_LEVEL1_UPPER, REG_LEVEL2_UPPER,
                    REG_LEVEL3_UPPER, REG_LEVEL4_UPPER: begin
                        upper_bound[i_cfg_index] = i_cfg_data[PCT_W-1:0];
                    end
                    REG_WAIT_BIG_GAP: begin
                        wait_far = i_cfg_data;
                    end
                    REG_WAIT_SMALL_GAP: begin
                        wait_near = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (level_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    mismatches++;
                end else begin
                    want = level_q.pop_front();
                    if (o_display_write !== want.display_write) begin
                        $error("display_write: expected %0d, got %0d",
                               want.display_write, o_display_write);
                        mismatches++;
                    end
                    if (o_shown_level !== want.shown_level) begin
                        $error("shown_level: expected %0d, got %0d",
                               want.shown_level, o_shown_level);
                        mismatches++;
                    end
                    if (o_low_fuel_warning !== want.low_fuel_warning) begin
                        $error("low_fuel_warning: expected %0d, got %0d",
                               want.low_fuel_warning, o_low_fuel_warning);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = step_gauge(i_action, i_fuel_percent);
                if (row_pinned) begin
                    want = row_result;
                end
                level_q.push_back(want);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_stim_row     dir_rows [$];
        int            vals [$];
        t_bounds       bnd;
        logic          act;
        logic [PCT_W-1:0] pct;
        int            pick;

        dir_rows = '{
            pinned_row(ACTION_TICK, 8'hAA, 1'b0, LEVEL_EMPTY, 1'b0),
            pinned_row(ACTION_UPDATE, INVALID_PERCENT, 1'b1, LEVEL_EMPTY, 1'b1),
            pinned_row(ACTION_UPDATE, 8'd0, 1'b0, LEVEL_EMPTY, 1'b1),
            pinned_row(ACTION_UPDATE, 8'd100, 1'b0, LEVEL_EMPTY, 1'b1),
            pinned_row(ACTION_UPDATE, 8'd11, 1'b0, LEVEL_EMPTY, 1'b1),
            pinned_row(ACTION_TICK, 8'h55, 1'b0, LEVEL_EMPTY, 1'b1),
            cfg_row(REG_WAIT_BIG_GAP, 16'd0),
            cfg_row(REG_WAIT_SMALL_GAP, 16'd2),
            cfg_row(CFG_IDX_UNUSED, 16'hFFFF),
            pinned_row(ACTION_UPDATE, 8'd254, 1'b1, 3'd1, 1'b0),
            item_row(ACTION_UPDATE, 8'd46),
            item_row(ACTION_UPDATE, 8'd26),
            item_row(ACTION_UPDATE, 8'd11),
            item_row(ACTION_TICK, 8'd0),
            item_row(ACTION_TICK, 8'd255),
            item_row(ACTION_UPDATE, 8'd11),
            item_row(ACTION_UPDATE, 8'd85),
            item_row(ACTION_UPDATE, 8'd86),
            // Bounds out of order: the first bound not exceeded decides the level.
            cfg_row(REG_LEVEL0_UPPER, 16'd200),
            cfg_row(REG_LEVEL1_UPPER, 16'd0),
            cfg_row(REG_LEVEL2_UPPER, 16'd254),
            cfg_row(REG_LEVEL3_UPPER, 16'd0),
            cfg_row(REG_LEVEL4_UPPER, 16'd0),
            cfg_row(REG_WAIT_SMALL_GAP, 16'd0),
            item_row(ACTION_UPDATE, 8'd0),
            item_row(ACTION_UPDATE, 8'd201),
            item_row(ACTION_UPDATE, INVALID_PERCENT),
            item_row(ACTION_UPDATE, 8'd100),
            item_row(ACTION_UPDATE, 8'd200),
            item_row(ACTION_UPDATE, 8'd254)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_pipe();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                push_item(dir_rows[i].act, dir_rows[i].pct, dir_rows[i].pinned, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 23 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                drain_pipe();
                vals = {};
                for (int i = 0; i < NUM_BOUNDS; i++) begin
                    vals.push_back($urandom_range(0, 130));
                end
                if ($urandom_range(0, 4) != 0) begin
                    vals.sort();
                end
                if ($urandom_range(0, 3) == 0) begin
                    vals[0] = 0;
                end
                if ($urandom_range(0, 3) == 0) begin
                    vals[NUM_BOUNDS-1] = 254;
                end
                for (int i = 0; i < NUM_BOUNDS; i++) begin
                    bnd[i] = PCT_W'(vals[i]);
                end
                load_gauge_settings(bnd, pick_wait(), pick_wait());
                // With no sender idling, a long receiver hold-off backs the block up.
                if (ph == 2 && seg == 0) begin
                    hold_req = 1'b1;
                end
                for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                    act = ($urandom_range(0, 99) < 55) ? ACTION_TICK : ACTION_UPDATE;
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        pct = INVALID_PERCENT;
                    end else if (pick == 1) begin
                        pct = PCT_W'($urandom_range(0, 255));
                    end else begin
                        pct = PCT_W'($urandom_range(0, 130));
                    end
                    push_item(act, pct, 1'b0, '0);
                end
            end
        end

        // Zero waits let every update step; the longest waits hold off every move.
        drain_pipe();
        bnd[0] = RST_LEVEL0_UPPER;
        bnd[1] = RST_LEVEL1_UPPER;
        bnd[2] = RST_LEVEL2_UPPER;
        bnd[3] = RST_LEVEL3_UPPER;
        bnd[4] = RST_LEVEL4_UPPER;
        load_gauge_settings(bnd, '0, '0);
        repeat (6) push_item(ACTION_UPDATE, INVALID_PERCENT, 1'b0, '0);
        drain_pipe();
        load_gauge_settings(bnd, TICK_MAX, TICK_MAX);
        push_item(ACTION_UPDATE, 8'd11, 1'b0, '0);
        repeat (6) push_item(ACTION_TICK, 8'd0, 1'b0, '0);
        push_item(ACTION_UPDATE, 8'd11, 1'b0, '0);
        push_item(ACTION_UPDATE, 8'd254, 1'b0, '0);
        repeat (6) push_item(ACTION_TICK, 8'hFF, 1'b0, '0);
        push_item(ACTION_UPDATE, 8'd254, 1'b0, '0);

        drain_pipe();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && level_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
